// ===== rtl/tte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_PACKET = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_CHUNK  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_DIRECTION   = 2'd0,
    CFG_WAIT_TICKS  = 2'd1,
    CFG_MAX_RETRIES = 2'd2,
    CFG_BLOCK_SIZE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_DONE = 2'd2,
    ST_FAIL = 2'd3
  } status_e;

  localparam logic [15:0] OP_RRQ    = 16'd1;
  localparam logic [15:0] OP_WRQ    = 16'd2;
  localparam logic [15:0] OP_DATA   = 16'd3;
  localparam logic [15:0] OP_ACK    = 16'd4;
  localparam logic [15:0] HDR_BYTES = 16'd4;

  localparam logic        DIRECTION_RESET   = 1'b0;
  localparam logic [15:0] WAIT_TICKS_RESET  = 16'd100;
  localparam logic [7:0]  MAX_RETRIES_RESET = 8'd3;
  localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;

  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CmdCntW  = $clog2(CmdDepth + 1);

  localparam int ResDepth = 2;
  localparam int ResPtrW  = (ResDepth > 1) ? $clog2(ResDepth) : 1;
  localparam int ResCntW  = $clog2(ResDepth + 1);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] pkt_len;
    logic [15:0] pkt_opcode;
    logic [15:0] pkt_block;
    logic [15:0] chunk_len;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_opcode;
    logic [15:0] send_block;
    logic [15:0] send_len;
    logic        deliver_valid;
    logic [15:0] deliver_len;
    logic        want_chunk;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        direction;
    logic [15:0] wait_ticks;
    logic [7:0]  max_retries;
    logic [15:0] block_size;
    logic [23:0] read_limit;
  } cfg_t;

  typedef struct packed {
    req_e        kind;
    logic        good_hdr;
    logic        is_data;
    logic        is_ack;
    logic        blk_zero;
    logic [15:0] blk;
    logic [15:0] pay;
    logic        pay_full;
    logic [15:0] chunk_len;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tte_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tte_front import tte_pkg::*; (
  input  var cfg_t     cfg_i,
  input  var in_item_t item_i,
  output cmd_t         cmd_o
);

  logic [15:0] pay;

  assign pay = item_i.pkt_len - HDR_BYTES;

  always_comb begin
    cmd_o.kind      = req_e'(item_i.req_type);
    cmd_o.good_hdr  = (item_i.req_type == REQ_PACKET) && (item_i.pkt_len >= HDR_BYTES);
    cmd_o.is_data   = (item_i.pkt_opcode == OP_DATA);
    cmd_o.is_ack    = (item_i.pkt_opcode == OP_ACK);
    cmd_o.blk_zero  = (item_i.pkt_block == 16'd0);
    cmd_o.blk       = item_i.pkt_block;
    cmd_o.pay       = pay;
    cmd_o.pay_full  = (pay == cfg_i.block_size);
    cmd_o.chunk_len = (item_i.chunk_len > cfg_i.block_size) ? cfg_i.block_size
                                                            : item_i.chunk_len;
  end

endmodule

`default_nettype wire

// ===== rtl/tte_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tte_cmd_queue import tte_pkg::*; (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic push_i,
  input  var cmd_t cmd_i,
  output logic     full_o,
  output logic     valid_o,
  output cmd_t     cmd_o,
  input  var logic pop_i
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wptr_q, rptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tte_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tte_back import tte_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var cfg_t      cfg_i,
  input  var logic      cmd_valid_i,
  input  var cmd_t      cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  output out_item_t     res_o,
  input  var logic      pop_i
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RD_WAIT  = 3'd1,
    PH_WR_ACK0  = 3'd2,
    PH_WR_CHUNK = 3'd3,
    PH_WR_ACK   = 3'd4,
    PH_DONE     = 3'd5,
    PH_FAIL     = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] block_number_q, block_number_d;
  logic [15:0] last_acked_q, last_acked_d;
  logic [23:0] wait_count_q, wait_count_d;
  logic [7:0]  retry_count_q, retry_count_d;
  logic [15:0] chunk_len_q, chunk_len_d;
  logic [23:0] wc_inc;
  out_item_t   res;

  out_item_t          res_mem_q [ResDepth];
  logic [ResPtrW-1:0] res_wptr_q, res_rptr_q;
  logic [ResCntW-1:0] res_cnt_q;
  logic               res_pop;

  assign wc_inc    = wait_count_q + 24'd1;
  assign res_pop   = pop_i && (res_cnt_q != '0);
  assign cmd_pop_o = cmd_valid_i && ((res_cnt_q != ResCntW'(ResDepth)) || res_pop);
  assign empty_o   = (res_cnt_q == '0);
  assign res_o     = res_mem_q[res_rptr_q];

  always_comb begin
    phase_d        = phase_q;
    block_number_d = block_number_q;
    last_acked_d   = last_acked_q;
    wait_count_d   = wait_count_q;
    retry_count_d  = retry_count_q;
    chunk_len_d    = chunk_len_q;
    res            = '0;
    case (phase_q)
      PH_IDLE, PH_DONE, PH_FAIL: begin
        if (cmd_i.kind == REQ_START) begin
          wait_count_d   = '0;
          retry_count_d  = '0;
          chunk_len_d    = '0;
          last_acked_d   = '0;
          res.send_valid = 1'b1;
          if (!cfg_i.direction) begin
            block_number_d  = 16'd1;
            phase_d         = PH_RD_WAIT;
            res.send_opcode = OP_RRQ;
          end else begin
            block_number_d  = 16'd0;
            phase_d         = PH_WR_ACK0;
            res.send_opcode = OP_WRQ;
          end
        end
      end
      PH_RD_WAIT: begin
        if (cmd_i.good_hdr && cmd_i.is_data && (cmd_i.blk == block_number_q)) begin
          res.send_valid    = 1'b1;
          res.send_opcode   = OP_ACK;
          res.send_block    = cmd_i.blk;
          res.deliver_valid = 1'b1;
          res.deliver_len   = cmd_i.pay;
          last_acked_d      = cmd_i.blk;
          wait_count_d      = '0;
          if (cmd_i.pay_full) begin
            block_number_d = block_number_q + 16'd1;
          end else begin
            phase_d = PH_DONE;
          end
        end else begin
          if (cmd_i.kind == REQ_TICK) begin
            res.send_valid  = 1'b1;
            res.send_opcode = OP_ACK;
            res.send_block  = last_acked_q;
          end
          wait_count_d = wc_inc;
          if (wc_inc >= cfg_i.read_limit) begin
            phase_d = PH_FAIL;
          end
        end
      end
      PH_WR_ACK0: begin
        if (cmd_i.good_hdr && cmd_i.is_ack && cmd_i.blk_zero) begin
          block_number_d = 16'd1;
          wait_count_d   = '0;
          phase_d        = PH_WR_CHUNK;
        end else begin
          wait_count_d = wc_inc;
          if (wc_inc >= {8'd0, cfg_i.wait_ticks}) begin
            phase_d = PH_FAIL;
          end
        end
      end
      PH_WR_CHUNK: begin
        if (cmd_i.kind == REQ_CHUNK) begin
          chunk_len_d     = cmd_i.chunk_len;
          res.send_valid  = 1'b1;
          res.send_opcode = OP_DATA;
          res.send_block  = block_number_q;
          res.send_len    = cmd_i.chunk_len;
          retry_count_d   = 8'd1;
          wait_count_d    = '0;
          phase_d         = PH_WR_ACK;
        end
      end
      PH_WR_ACK: begin
        if (cmd_i.good_hdr && cmd_i.is_ack && (cmd_i.blk == block_number_q)) begin
          wait_count_d  = '0;
          retry_count_d = '0;
          if (chunk_len_q == cfg_i.block_size) begin
            block_number_d = block_number_q + 16'd1;
            phase_d        = PH_WR_CHUNK;
          end else begin
            phase_d = PH_DONE;
          end
        end else begin
          wait_count_d = wc_inc;
          if (wc_inc >= {8'd0, cfg_i.wait_ticks}) begin
            if (retry_count_q >= cfg_i.max_retries) begin
              phase_d = PH_FAIL;
            end else begin
              res.send_valid  = 1'b1;
              res.send_opcode = OP_DATA;
              res.send_block  = block_number_q;
              res.send_len    = chunk_len_q;
              retry_count_d   = retry_count_q + 8'd1;
              wait_count_d    = '0;
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    res.want_chunk = (phase_d == PH_WR_CHUNK);
    case (phase_d)
      PH_IDLE: res.status = ST_IDLE;
      PH_DONE: res.status = ST_DONE;
      PH_FAIL: res.status = ST_FAIL;
      default: res.status = ST_BUSY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      block_number_q <= '0;
      last_acked_q   <= '0;
      wait_count_q   <= '0;
      retry_count_q  <= '0;
      chunk_len_q    <= '0;
      res_wptr_q     <= '0;
      res_rptr_q     <= '0;
      res_cnt_q      <= '0;
    end else begin
      if (cmd_pop_o) begin
        phase_q        <= phase_d;
        block_number_q <= block_number_d;
        last_acked_q   <= last_acked_d;
        wait_count_q   <= wait_count_d;
        retry_count_q  <= retry_count_d;
        chunk_len_q    <= chunk_len_d;
        res_wptr_q     <= (res_wptr_q == ResPtrW'(ResDepth - 1)) ? '0 : res_wptr_q + 1'b1;
      end
      if (res_pop) begin
        res_rptr_q <= (res_rptr_q == ResPtrW'(ResDepth - 1)) ? '0 : res_rptr_q + 1'b1;
      end
      if (cmd_pop_o && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !cmd_pop_o) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_mem_q[res_wptr_q] <= res;
    end
  end

  // The result buffer never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= ResCntW'(ResDepth))
    else $error("result buffer overflow");

  // A start seen in idle always opens a read or a write transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && (phase_q == PH_IDLE) && (cmd_i.kind == REQ_START))
    |=> ((phase_q == PH_RD_WAIT) || (phase_q == PH_WR_ACK0)))
    else $error("start did not open a transfer");

  // A chunk request in write mode always produces one DATA transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && (phase_q == PH_WR_CHUNK) && (cmd_i.kind == REQ_CHUNK))
    |=> ((phase_q == PH_WR_ACK) && (retry_count_q == 8'd1)))
    else $error("chunk did not start a send");

  // The wait counter is cleared when an acknowledged write block leads to the next chunk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && (phase_q == PH_WR_ACK) && (phase_d == PH_WR_CHUNK))
    |=> (wait_count_q == '0))
    else $error("wait counter not cleared on acknowledged block");

endmodule

`default_nettype wire

// ===== rtl/tftp_transfer_engine.sv =====
// Events wait in the command queue; the back end puts each result in the result buffer.
// Throughput: one event per cycle while the result buffer has room or is being read.
// A two-entry command queue and a two-entry result buffer decouple the two sides.
// Reset (rst_ni low, asynchronous) returns to idle with default configuration.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module tftp_transfer_engine import tte_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      push,
  output logic          full,
  input  var in_item_t  in_i,
  output logic          empty,
  input  var logic      pop,
  output out_item_t     out_o,
  input  var logic      cfg_valid_i,
  output logic          cfg_ready_o,
  input  var logic [1:0]  cfg_index_i,
  input  var logic [15:0] cfg_data_i
);

  cfg_t        cfg;
  logic        direction_q;
  logic [15:0] wait_ticks_q;
  logic [7:0]  max_retries_q;
  logic [15:0] block_size_q;
  logic [23:0] read_limit_q;
  cmd_t        front_cmd, queue_cmd;
  logic        queue_valid, queue_pop;

  assign cfg_ready_o = 1'b1;

  assign cfg.direction   = direction_q;
  assign cfg.wait_ticks  = wait_ticks_q;
  assign cfg.max_retries = max_retries_q;
  assign cfg.block_size  = block_size_q;
  assign cfg.read_limit  = read_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q   <= DIRECTION_RESET;
      wait_ticks_q  <= WAIT_TICKS_RESET;
      max_retries_q <= MAX_RETRIES_RESET;
      block_size_q  <= BLOCK_SIZE_RESET;
      read_limit_q  <= 24'(WAIT_TICKS_RESET) * 24'(MAX_RETRIES_RESET);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DIRECTION:   direction_q   <= cfg_data_i[0];
          CFG_WAIT_TICKS:  wait_ticks_q  <= cfg_data_i;
          CFG_MAX_RETRIES: max_retries_q <= cfg_data_i[7:0];
          CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i;
          default: ;
        endcase
      end
      read_limit_q <= 24'(wait_ticks_q) * 24'(max_retries_q);
    end
  end

  tte_front u_front (
    .cfg_i  (cfg),
    .item_i (in_i),
    .cmd_o  (front_cmd)
  );

  tte_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd),
    .pop_i   (queue_pop)
  );

  tte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .empty_o     (empty),
    .res_o       (out_o),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire

// ===== dv/tb_tftp_transfer_engine.sv =====
`timescale 1ns / 1ps

module tb_tftp_transfer_engine;
  import tte_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 1200;
  localparam int MaxChunk      = 65464;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RD_WAIT,
    PH_WR_ACK0,
    PH_WR_CHUNK,
    PH_WR_ACK,
    PH_DONE,
    PH_FAIL
  } xfer_phase_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    stim_item   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  out_item_t   result_item;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  // Register values as the engine should currently see them.
  logic        set_dir     = DIRECTION_RESET;
  logic [15:0] set_wait    = WAIT_TICKS_RESET;
  logic [7:0]  set_retries = MAX_RETRIES_RESET;
  logic [15:0] set_bsize   = BLOCK_SIZE_RESET;

  // Transfer state of the predicted engine.
  xfer_phase_e eng_phase = PH_IDLE;
  logic [15:0] eng_block = '0;
  logic [15:0] eng_acked = '0;
  logic [23:0] eng_waits = '0;
  logic [7:0]  eng_sends = '0;
  logic [15:0] eng_chunk = '0;

  in_item_t  pending_events[$];
  out_item_t predicted_results[$];
  out_item_t want_res;

  bit idle_en      = 1'b1;
  int made_items   = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  int stall_cycles = 0;
  int mismatches   = 0;
  int n_results    = 0;

  tftp_transfer_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (stim_item),
    .empty       (empty),
    .pop         (pop),
    .out_o       (result_item),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_item_t send_packet(input logic [15:0] op, input logic [15:0] blk,
                                            input logic [15:0] len);
    out_item_t r;
    r = '0;
    r.send_valid  = 1'b1;
    r.send_opcode = op;
    r.send_block  = blk;
    r.send_len    = len;
    return r;
  endfunction

  function automatic out_item_t engine_step(input in_item_t ev);
    out_item_t   r;
    logic        good_hdr;
    logic [15:0] pay;
    logic [31:0] read_limit;
    r = '0;
    good_hdr = (ev.req_type == REQ_PACKET) && (ev.pkt_len >= HDR_BYTES);
    pay = ev.pkt_len - HDR_BYTES;
    read_limit = 32'(set_wait) * 32'(set_retries);
    case (eng_phase)
      PH_IDLE, PH_DONE, PH_FAIL: begin
        if (ev.req_type == REQ_START) begin
          eng_waits = '0;
          eng_sends = '0;
          eng_chunk = '0;
          eng_acked = '0;
          if (set_dir == 1'b0) begin
            eng_block = 16'd1;
            eng_phase = PH_RD_WAIT;
            r = send_packet(OP_RRQ, '0, '0);
          end else begin
            eng_block = '0;
            eng_phase = PH_WR_ACK0;
            r = send_packet(OP_WRQ, '0, '0);
          end
        end
      end
      PH_RD_WAIT: begin
        if (good_hdr && ev.pkt_opcode == OP_DATA && ev.pkt_block == eng_block) begin
          r = send_packet(OP_ACK, ev.pkt_block, '0);
          r.deliver_valid = 1'b1;
          r.deliver_len   = pay;
          eng_acked = ev.pkt_block;
          eng_waits = '0;
          if (pay == set_bsize) begin
            eng_block = eng_block + 16'd1;
          end else begin
            eng_phase = PH_DONE;
          end
        end else begin
          if (ev.req_type == REQ_TICK) begin
            r = send_packet(OP_ACK, eng_acked, '0);
          end
          eng_waits = eng_waits + 24'd1;
          if (32'(eng_waits) >= read_limit) begin
            eng_phase = PH_FAIL;
          end
        end
      end
      PH_WR_ACK0: begin
        if (good_hdr && ev.pkt_opcode == OP_ACK && ev.pkt_block == 16'd0) begin
          eng_block = 16'd1;
          eng_waits = '0;
          eng_phase = PH_WR_CHUNK;
        end else begin
          eng_waits = eng_waits + 24'd1;
          if (eng_waits >= set_wait) begin
            eng_phase = PH_FAIL;
          end
        end
      end
      PH_WR_CHUNK: begin
        if (ev.req_type == REQ_CHUNK) begin
          eng_chunk = (ev.chunk_len > set_bsize) ? set_bsize : ev.chunk_len;
          r = send_packet(OP_DATA, eng_block, eng_chunk);
          eng_sends = 8'd1;
          eng_waits = '0;
          eng_phase = PH_WR_ACK;
        end
      end
      PH_WR_ACK: begin
        if (good_hdr && ev.pkt_opcode == OP_ACK && ev.pkt_block == eng_block) begin
          eng_waits = '0;
          eng_sends = '0;
          if (eng_chunk == set_bsize) begin
            eng_block = eng_block + 16'd1;
            eng_phase = PH_WR_CHUNK;
          end else begin
            eng_phase = PH_DONE;
          end
        end else begin
          eng_waits = eng_waits + 24'd1;
          if (eng_waits >= set_wait) begin
            if (eng_sends >= set_retries) begin
              eng_phase = PH_FAIL;
            end else begin
              r = send_packet(OP_DATA, eng_block, eng_chunk);
              eng_sends = eng_sends + 8'd1;
              eng_waits = '0;
            end
          end
        end
      end
      default: begin
        eng_phase = PH_IDLE;
      end
    endcase
    r.want_chunk = (eng_phase == PH_WR_CHUNK);
    case (eng_phase)
      PH_IDLE: r.status = ST_IDLE;
      PH_DONE: r.status = ST_DONE;
      PH_FAIL: r.status = ST_FAIL;
      default: r.status = ST_BUSY;
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int any16();
    return $urandom_range(0, 65535);
  endfunction

  function automatic int any_clen();
    return $urandom_range(0, MaxChunk);
  endfunction

  // Number of stray events to put in front of an expected reply.
  function automatic int draw_noise(input int limit);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 8) return $urandom_range(1, 2);
    return $urandom_range(0, (limit < 24) ? limit : 24);
  endfunction

  task automatic compare_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: %s expected %0d, got %0d", n_results, fname, want, got);
      end
    end
  endtask

  task automatic add_ev(input req_e kind, input int len, input int op, input int blk,
                        input int clen);
    in_item_t ev;
    ev.req_type   = kind;
    ev.pkt_len    = 16'(len);
    ev.pkt_opcode = 16'(op);
    ev.pkt_block  = 16'(blk);
    ev.chunk_len  = 16'(clen);
    pending_events.push_back(ev);
    made_items++;
  endtask

  task automatic add_noise(input bit chunk_ok, input logic [15:0] blk);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_ev(REQ_TICK, any16(), any16(), any16(), any_clen());
      4: add_ev(REQ_START, any16(), any16(), any16(), any_clen());
      5: add_ev(REQ_PACKET, $urandom_range(0, 3), $urandom_range(0, 1) ? OP_DATA : OP_ACK,
                blk, any_clen());
      6: add_ev(REQ_PACKET, any16(), any16(), any16(), any_clen());
      7: add_ev(REQ_PACKET, $urandom_range(4, 600), $urandom_range(0, 1) ? OP_DATA : OP_ACK,
                $urandom_range(0, 1) ? blk + 16'd1 : blk - 16'd1, any_clen());
      8: begin
        if (chunk_ok) begin
          add_ev(REQ_CHUNK, any16(), any16(), any16(), any_clen());
        end else begin
          add_ev(REQ_TICK, any16(), any16(), any16(), any_clen());
        end
      end
      default: add_ev(REQ_PACKET, $urandom_range(4, 65535), $urandom_range(5, 65535), blk,
                      any_clen());
    endcase
  endtask

  task automatic gen_read(input int nblk);
    logic [15:0] blk;
    int          lim;
    int          len;
    int          bs;
    int          r;
    lim = int'(set_wait) * int'(set_retries);
    bs = int'(set_bsize);
    blk = 16'd1;
    add_ev(REQ_START, any16(), any16(), any16(), any_clen());
    for (int i = 0; i <= nblk; i++) begin
      repeat (draw_noise(lim)) add_noise(1'b1, blk);
      if (i < nblk) begin
        len = bs + 4;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7) len = $urandom_range(4, bs + 3);
        else if (r < 9 || bs + 5 > 65535) len = 4;
        else len = $urandom_range(bs + 5, 65535);
      end
      add_ev(REQ_PACKET, len, OP_DATA, blk, any_clen());
      blk = blk + 16'd1;
    end
    if ($urandom_range(0, 3) == 0) add_noise(1'b1, blk);
  endtask

  task automatic gen_write(input int nblk);
    logic [15:0] blk;
    int          clen;
    int          bs;
    bs = int'(set_bsize);
    blk = 16'd1;
    add_ev(REQ_START, any16(), any16(), any16(), any_clen());
    repeat (draw_noise(int'(set_wait))) add_noise(1'b1, '0);
    add_ev(REQ_PACKET, $urandom_range(0, 1) ? 4 : any16() | 4, OP_ACK, 0, any_clen());
    for (int i = 0; i <= nblk; i++) begin
      if ($urandom_range(0, 3) == 0) add_noise(1'b0, blk);
      if (i == nblk) clen = $urandom_range(0, bs - 1);
      else if ($urandom_range(0, 4) != 0) clen = bs;
      else clen = $urandom_range(bs, MaxChunk);
      add_ev(REQ_CHUNK, any16(), any16(), any16(), clen);
      repeat (draw_noise(int'(set_wait) * int'(set_retries))) add_noise(1'b1, blk);
      add_ev(REQ_PACKET, $urandom_range(0, 1) ? 4 : any16() | 4, OP_ACK, blk, any_clen());
      blk = blk + 16'd1;
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DIRECTION:   set_dir     = val[0];
      CFG_WAIT_TICKS:  set_wait    = val;
      CFG_MAX_RETRIES: set_retries = val[7:0];
      CFG_BLOCK_SIZE:  set_bsize   = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    while (pending_events.size() != 0 || push || predicted_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic random_phase(input int idx);
    logic dir;
    int   wt;
    int   rt;
    int   bs;
    int   goal;
    dir = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       wt = 65535;
      1, 2:    wt = $urandom_range(7, 100);
      default: wt = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 9))
      0:       rt = 255;
      1, 2:    rt = $urandom_range(5, 20);
      default: rt = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 9))
      0:       bs = MaxChunk;
      1:       bs = 8;
      2:       bs = $urandom_range(41, 1500);
      default: bs = $urandom_range(8, 40);
    endcase
    if (idx == 0) begin
      wt = 1;
      rt = 1;
    end
    if (idx == 1) begin
      wt = 65535;
      rt = 255;
      bs = MaxChunk;
    end
    idle_en = ($urandom_range(0, 3) != 0);
    write_reg(CFG_DIRECTION, {15'($urandom), dir});
    write_reg(CFG_WAIT_TICKS, 16'(wt));
    write_reg(CFG_MAX_RETRIES, {8'($urandom), 8'(rt)});
    write_reg(CFG_BLOCK_SIZE, 16'(bs));
    goal = made_items + 60;
    while (made_items < goal) begin
      if (set_dir) begin
        gen_write(($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5));
      end else begin
        gen_read(($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5));
      end
    end
    wait_quiet();
  endtask

  always @(posedge clk_i) begin
    if (push && !full) begin
      predicted_results.push_back(engine_step(stim_item));
      gap_left = draw_gap();
    end
    if (!push || !full) begin
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_events.size() != 0) begin
        stim_item <= pending_events.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing predicted", n_results);
        end
      end else begin
        want_res = predicted_results.pop_front();
        compare_field("send_valid", want_res.send_valid, result_item.send_valid);
        compare_field("send_opcode", want_res.send_opcode, result_item.send_opcode);
        compare_field("send_block", want_res.send_block, result_item.send_block);
        compare_field("send_len", want_res.send_len, result_item.send_len);
        compare_field("deliver_valid", want_res.deliver_valid, result_item.deliver_valid);
        compare_field("deliver_len", want_res.deliver_len, result_item.deliver_len);
        compare_field("want_chunk", want_res.want_chunk, result_item.want_chunk);
        compare_field("status", want_res.status, result_item.status);
      end
      n_results++;
      hold_left = draw_gap();
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("[tftp_transfer_engine] ERROR");
      $finish;
    end
  end

  initial begin
    int rand_goal;
    int ph;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Read transfer with the power-on register values.
    add_ev(REQ_TICK, 516, OP_DATA, 1, 0);
    add_ev(REQ_START, 0, 0, 0, 0);
    add_ev(REQ_START, 0, 0, 0, 0);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    add_ev(REQ_PACKET, 3, OP_DATA, 1, 0);
    add_ev(REQ_PACKET, 516, OP_ACK, 1, 0);
    add_ev(REQ_PACKET, 516, OP_DATA, 2, 0);
    add_ev(REQ_PACKET, 516, OP_DATA, 1, 0);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    add_ev(REQ_PACKET, 65535, OP_DATA, 2, 0);
    add_ev(REQ_START, 0, 0, 0, 0);
    add_ev(REQ_PACKET, 4, OP_DATA, 1, 0);
    wait_quiet();

    // Write transfer with a clamped chunk and one resend of each of its two blocks.
    write_reg(CFG_DIRECTION, 16'hFFFF);
    write_reg(CFG_WAIT_TICKS, 16'd2);
    write_reg(CFG_MAX_RETRIES, 16'hFF02);
    write_reg(CFG_BLOCK_SIZE, 16'd8);
    add_ev(REQ_START, 0, 0, 0, 0);
    add_ev(REQ_PACKET, 3, OP_ACK, 0, 0);
    add_ev(REQ_PACKET, 4, OP_ACK, 0, 0);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    add_ev(REQ_CHUNK, 0, 0, 0, MaxChunk);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    add_ev(REQ_PACKET, 4, OP_ACK, 1, 0);
    add_ev(REQ_CHUNK, 0, 0, 0, 3);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    wait_quiet();

    // Zero limits fail on the first waiting event in both directions.
    write_reg(CFG_WAIT_TICKS, 16'd0);
    write_reg(CFG_MAX_RETRIES, 16'hFF00);
    add_ev(REQ_START, 0, 0, 0, 0);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    wait_quiet();
    write_reg(CFG_DIRECTION, 16'h0000);
    add_ev(REQ_START, 0, 0, 0, 0);
    add_ev(REQ_TICK, 0, 0, 0, 0);
    wait_quiet();

    rand_goal = made_items + RandomItems;
    ph = 0;
    while (made_items < rand_goal) begin
      random_phase(ph);
      ph++;
    end

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("[tftp_transfer_engine] OK");
    end else begin
      $display("[tftp_transfer_engine] ERROR");
    end
    $finish;
  end

endmodule
